@@ rtl/mtcr_pkg.sv @@
// ----------------------------------------------------------------------------
// mtcr_pkg: shared definitions for the magnetic tape controller registers
// Field widths, status and command bit masks, operation codes and the item
// and result records that pass between the top level and the execute logic.
// ----------------------------------------------------------------------------
package mtcr_pkg;

	// Drive masks always carry eight drives; fewer may be populated.
	localparam int UNIT_SLOTS    = 8;
	localparam int NUM_UNITS_DEF = 8;

	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 48;

	// Item kinds carried on the input tuser.
	localparam logic [2:0] MODE_IOT    = 3'd0;
	localparam logic [2:0] MODE_DONE   = 3'd1;
	localparam logic [2:0] MODE_REWIND = 3'd2;
	localparam logic [2:0] MODE_ATTACH = 3'd3;
	localparam logic [2:0] MODE_DETACH = 3'd4;

	// IOT subop, pulse bits 5..4.
	localparam logic [1:0] SUB_UNIT = 2'd0;
	localparam logic [1:0] SUB_CTL  = 2'd1;
	localparam logic [1:0] SUB_STAT = 2'd2;

	// Function codes held in command bits 11..9.
	localparam logic [2:0] FN_NOP     = 3'd0;
	localparam logic [2:0] FN_RWD     = 3'd1;
	localparam logic [2:0] FN_READ    = 3'd2;
	localparam logic [2:0] FN_CMP     = 3'd3;
	localparam logic [2:0] FN_WRT     = 3'd4;
	localparam logic [2:0] FN_WEOF    = 3'd5;
	localparam logic [2:0] FN_SPC_FWD = 3'd6;
	localparam logic [2:0] FN_SPC_REV = 3'd7;

	// Tape result codes.
	localparam logic [3:0] RC_OK     = 4'd0;
	localparam logic [3:0] RC_TMK    = 4'd1;
	localparam logic [3:0] RC_IOERR  = 4'd2;
	localparam logic [3:0] RC_RECE   = 4'd3;
	localparam logic [3:0] RC_BADLEN = 4'd4;
	localparam logic [3:0] RC_EOM    = 4'd5;
	localparam logic [3:0] RC_BOT    = 4'd6;
	localparam logic [3:0] RC_WPROT  = 4'd7;
	localparam logic [3:0] RC_FMT    = 4'd8;

	// Status register bits.
	localparam logic [17:0] S_ERR = 18'o400000;
	localparam logic [17:0] S_REW = 18'o200000;
	localparam logic [17:0] S_BOT = 18'o100000;
	localparam logic [17:0] S_ILL = 18'o040000;
	localparam logic [17:0] S_PAR = 18'o020000;
	localparam logic [17:0] S_EOF = 18'o010000;
	localparam logic [17:0] S_EOT = 18'o004000;
	localparam logic [17:0] S_CPE = 18'o002000;
	localparam logic [17:0] S_RLE = 18'o001000;
	localparam logic [17:0] S_BAD = 18'o000200;
	localparam logic [17:0] S_DON = 18'o000100;
	localparam logic [17:0] S_LOW = 18'o000077;
	localparam logic [17:0] S_DYN = S_REW | S_BOT | S_EOF | S_EOT;

	// Command register masks and bits.
	localparam logic [17:0] CMD_KEEP = 18'o770700;
	localparam logic [17:0] CMD_LOAD = 18'o777700;
	localparam int          CMD_ERASE_BIT = 12;
	localparam int          CMD_IE_BIT    = 8;

	// Per-drive status bits.
	localparam logic [3:0] US_REW = 4'b1000;
	localparam logic [3:0] US_BOT = 4'b0100;
	localparam logic [3:0] US_EOF = 4'b0010;
	localparam logic [3:0] US_EOT = 4'b0001;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  pulse;
		logic [17:0] ac_in;
		logic [2:0]  unit;
		logic [3:0]  result_code;
		logic        length_error;
		logic        compare_error;
		logic        eot_before;
		logic        eot_after;
		logic [7:0]  attached_mask;
		logic [7:0]  active_mask;
		logic [7:0]  locked_mask;
	} item_t;

	typedef struct packed {
		logic [17:0] ac_out;
		logic        skip;
		logic [17:0] status_word;
		logic        irq;
		logic        start_res;
		logic [2:0]  start_function;
		logic [2:0]  start_unit;
	} result_t;

endpackage

@@ rtl/mtcr_exec.sv @@
// ----------------------------------------------------------------------------
// mtcr_exec: item execution logic
// Combinational next state and result for one IOT or drive event, given the
// current command, status and per-drive registers.
// ----------------------------------------------------------------------------
module mtcr_exec #(
	parameter int NUM_UNITS = mtcr_pkg::NUM_UNITS_DEF
) (
	input  mtcr_pkg::item_t   item,
	input  logic [17:0]       cmd,
	input  logic [17:0]       stat,
	input  logic [3:0]        us [NUM_UNITS],
	input  logic              fresh,
	output logic [17:0]       cmd_nxt,
	output logic [17:0]       stat_nxt,
	output logic [3:0]        us_nxt [NUM_UNITS],
	output mtcr_pkg::result_t res
);

	typedef logic [3:0] us_arr_t [NUM_UNITS];

	// Drives at or beyond NUM_UNITS read as zero and are never written.
	function automatic logic [3:0] us_get(us_arr_t a, logic [2:0] idx);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < NUM_UNITS; i++)
			if (idx == 3'(i)) r = a[i];
		return r;
	endfunction

	function automatic us_arr_t us_set(us_arr_t a, logic [2:0] idx, logic [3:0] v);
		us_arr_t r;
		r = a;
		for (int i = 0; i < NUM_UNITS; i++)
			if (idx == 3'(i)) r[i] = v;
		return r;
	endfunction

	function automatic logic mbit(logic [7:0] m, logic [2:0] idx);
		logic r;
		r = 1'b0;
		for (int i = 0; i < NUM_UNITS; i++)
			if (idx == 3'(i)) r = m[i];
		return r;
	endfunction

	function automatic logic unit_ok(logic [2:0] idx);
		logic r;
		r = 1'b0;
		for (int i = 0; i < NUM_UNITS; i++)
			if (idx == 3'(i)) r = 1'b1;
		return r;
	endfunction

	function automatic logic [17:0] dyn(logic [3:0] v);
		return {1'b0, v[3], v[2], 2'b00, v[1], v[0], 11'b0};
	endfunction

	function automatic logic [17:0] merge(logic [17:0] sfv, logic [3:0] usv,
		logic [17:0] news);
		return (sfv & ~(mtcr_pkg::S_DYN | mtcr_pkg::S_LOW)) | dyn(usv) | news;
	endfunction

	function automatic logic [17:0] map_sf(logic [3:0] rc);
		logic [17:0] r;
		r = '0;
		case (rc)
			mtcr_pkg::RC_TMK, mtcr_pkg::RC_BOT: r = mtcr_pkg::S_ERR;
			mtcr_pkg::RC_IOERR, mtcr_pkg::RC_RECE, mtcr_pkg::RC_BADLEN:
				r = mtcr_pkg::S_PAR | mtcr_pkg::S_ERR;
			mtcr_pkg::RC_EOM: r = mtcr_pkg::S_BAD | mtcr_pkg::S_ERR;
			mtcr_pkg::RC_WPROT, mtcr_pkg::RC_FMT: r = mtcr_pkg::S_ILL | mtcr_pkg::S_ERR;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] map_us(logic [3:0] rc);
		logic [3:0] r;
		r = '0;
		case (rc)
			mtcr_pkg::RC_TMK: r = mtcr_pkg::US_EOF;
			mtcr_pkg::RC_BOT: r = mtcr_pkg::US_BOT;
			default: r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		logic [17:0] cu;
		logic [17:0] sf;
		logic [17:0] ac;
		us_arr_t     u_st;
		logic [2:0]  sel;
		logic [2:0]  fn;
		logic [1:0]  sb;
		logic [3:0]  usel;
		logic [3:0]  uu;
		logic        busy;
		logic        bad_go;
		logic        skip;
		logic        go;
		logic [2:0]  go_fn;
		logic [2:0]  go_un;

		cu    = cmd;
		sf    = stat;
		ac    = '0;
		u_st  = us;
		skip  = 1'b0;
		go    = 1'b0;
		go_fn = '0;
		go_un = '0;
		busy  = 1'b0;

		// The first item after reset puts every attached drive at BOT.
		if (fresh) begin
			for (int i = 0; i < NUM_UNITS; i++)
				u_st[i] = item.attached_mask[i] ? mtcr_pkg::US_BOT : 4'b0000;
		end

		for (int i = 0; i < NUM_UNITS; i++)
			if (item.active_mask[i] && !u_st[i][3]) busy = 1'b1;

		sel    = cu[17:15];
		fn     = cu[11:9];
		sb     = item.pulse[5:4];
		usel   = us_get(u_st, sel);
		uu     = us_get(u_st, item.unit);
		bad_go = 1'b0;

		case (item.mode)
			mtcr_pkg::MODE_IOT: begin
				ac = item.ac_in;
				sf = merge(sf, usel, '0);
				if (item.pulse[0]) begin
					case (sb)
						mtcr_pkg::SUB_UNIT:
							skip = mbit(item.attached_mask, sel) &&
								!mbit(item.active_mask, sel);
						mtcr_pkg::SUB_CTL:  skip = !busy;
						mtcr_pkg::SUB_STAT: skip = |(sf & (mtcr_pkg::S_ERR | mtcr_pkg::S_DON));
						default: ;
					endcase
				end
				if (item.pulse[1]) begin
					case (sb)
						mtcr_pkg::SUB_UNIT: ac = ac | (cu & mtcr_pkg::CMD_LOAD);
						mtcr_pkg::SUB_CTL: begin
							if (!busy) begin
								cu = '0;
								sf = '0;
							end
							sf = sf & ~(mtcr_pkg::S_ERR | mtcr_pkg::S_DON);
						end
						mtcr_pkg::SUB_STAT: ac = ac | sf;
						default: ;
					endcase
				end
				if (item.pulse[2]) begin
					case (sb)
						mtcr_pkg::SUB_UNIT: begin
							bad_go = busy || mbit(item.active_mask, sel) ||
								(fn == mtcr_pkg::FN_NOP) ||
								(((fn == mtcr_pkg::FN_SPC_REV) ||
								(fn == mtcr_pkg::FN_RWD)) && usel[2]) ||
								(((fn == mtcr_pkg::FN_WRT) ||
								(fn == mtcr_pkg::FN_WEOF)) &&
								mbit(item.locked_mask, sel)) ||
								!mbit(item.attached_mask, sel);
							if (bad_go) begin
								sf = sf | mtcr_pkg::S_ILL | mtcr_pkg::S_ERR;
							end else begin
								if (fn == mtcr_pkg::FN_RWD) begin
									u_st = us_set(u_st, sel, mtcr_pkg::US_REW);
								end else begin
									u_st = us_set(u_st, sel, 4'b0000);
									sf   = '0;
								end
								go    = 1'b1;
								go_fn = fn;
								go_un = sel;
							end
						end
						mtcr_pkg::SUB_CTL:
							cu = (cu & mtcr_pkg::CMD_KEEP) | (ac & mtcr_pkg::CMD_LOAD);
						default: ;
					endcase
				end
				sf = merge(sf, us_get(u_st, cu[17:15]), '0);
			end
			mtcr_pkg::MODE_DONE, mtcr_pkg::MODE_REWIND: begin
				if (unit_ok(item.unit)) begin
					// A completion on a rewinding drive is its rewind end.
					if ((item.mode == mtcr_pkg::MODE_REWIND) || uu[3]) begin
						u_st = us_set(u_st, item.unit,
							mbit(item.attached_mask, item.unit) ? mtcr_pkg::US_BOT : 4'b0000);
						if (item.unit == sel)
							sf = merge(sf, us_get(u_st, item.unit), mtcr_pkg::S_DON);
					end else if (!mbit(item.attached_mask, item.unit)) begin
						sf = merge(sf, uu, mtcr_pkg::S_ILL);
					end else begin
						case (fn)
							mtcr_pkg::FN_READ, mtcr_pkg::FN_CMP: begin
								if ((item.result_code != mtcr_pkg::RC_OK) &&
									(item.result_code != mtcr_pkg::RC_RECE)) begin
									sf = sf | mtcr_pkg::S_RLE | mtcr_pkg::S_ERR |
										map_sf(item.result_code);
									u_st = us_set(u_st, item.unit,
										uu | map_us(item.result_code));
								end else begin
									if (item.result_code == mtcr_pkg::RC_RECE)
										sf = sf | mtcr_pkg::S_PAR | mtcr_pkg::S_ERR;
									if (item.length_error)
										sf = sf | mtcr_pkg::S_RLE | mtcr_pkg::S_ERR;
									if ((fn == mtcr_pkg::FN_CMP) && item.compare_error)
										sf = merge(sf, uu, mtcr_pkg::S_CPE);
								end
							end
							mtcr_pkg::FN_WRT: begin
								sf   = sf | map_sf(item.result_code);
								u_st = us_set(u_st, item.unit, uu | map_us(item.result_code));
								cu[mtcr_pkg::CMD_ERASE_BIT] = 1'b0;
							end
							mtcr_pkg::FN_WEOF: begin
								if (item.result_code != mtcr_pkg::RC_OK) begin
									sf   = sf | map_sf(item.result_code);
									u_st = us_set(u_st, item.unit,
										uu | map_us(item.result_code));
								end else begin
									u_st = us_set(u_st, item.unit, mtcr_pkg::US_EOF);
								end
								cu[mtcr_pkg::CMD_ERASE_BIT] = 1'b0;
							end
							mtcr_pkg::FN_SPC_FWD, mtcr_pkg::FN_SPC_REV: begin
								sf   = sf | map_sf(item.result_code);
								u_st = us_set(u_st, item.unit, uu | map_us(item.result_code));
							end
							default: ;
						endcase
						if (!item.eot_before && item.eot_after)
							u_st = us_set(u_st, item.unit,
								us_get(u_st, item.unit) | mtcr_pkg::US_EOT);
						sf = merge(sf, us_get(u_st, item.unit), mtcr_pkg::S_DON);
					end
				end
			end
			mtcr_pkg::MODE_ATTACH: begin
				if (unit_ok(item.unit)) begin
					u_st = us_set(u_st, item.unit, mtcr_pkg::US_BOT);
					sf   = merge(sf, us_get(u_st, sel), '0);
				end
			end
			mtcr_pkg::MODE_DETACH: begin
				if (unit_ok(item.unit) && mbit(item.attached_mask, item.unit)) begin
					if (!mbit(item.active_mask, item.unit))
						u_st = us_set(u_st, item.unit, 4'b0000);
					sf = merge(sf, us_get(u_st, sel), '0);
				end
			end
			default: ;
		endcase

		cmd_nxt  = cu;
		stat_nxt = sf;
		us_nxt   = u_st;

		res.ac_out         = ac;
		res.skip           = skip;
		res.status_word    = sf;
		res.irq            = (|(sf & (mtcr_pkg::S_ERR | mtcr_pkg::S_DON))) &&
			cu[mtcr_pkg::CMD_IE_BIT];
		res.start_res      = go;
		res.start_function = go_fn;
		res.start_unit     = go_un;
	end

endmodule

@@ rtl/magtape_controller_registers.sv @@
// ----------------------------------------------------------------------------
// magtape_controller_registers: magnetic tape controller register block
// Executes processor IOTs against the command and status registers and
// applies drive events (completion, rewind done, attach, detach).
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                     Contents
//  s_axis    in         tvalid tready tdata tuser   one IOT or drive event
//  m_axis    out        tvalid tready tdata         one result per item
//
// One item per cycle sustained while the output is ready; a result passes from
// its input transfer through the input register, the execute logic and the
// result register. Register state updates as an item moves into the result
// register. A stalled output holds the result and lets one more item wait in
// the input register. Reset empties both stages and clears the command, status
// and drive registers; the first item afterwards marks its attached drives at
// BOT before it acts.
module magtape_controller_registers #(
	parameter int NUM_UNITS = mtcr_pkg::NUM_UNITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// pulse, ac_in, unit, result_code, length_error, compare_error, eot_before,
	// eot_after, attached_mask, active_mask, locked_mask, zero fill
	input  logic [mtcr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic [mtcr_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// ac_out, skip, status_word, irq, start_res, start_function, start_unit,
	// zero fill
	output logic [mtcr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	mtcr_pkg::item_t   item_in;
	mtcr_pkg::item_t   item_s1;
	mtcr_pkg::result_t res_nxt;
	mtcr_pkg::result_t res_s2;
	logic              vld_s1;
	logic              vld_s2;
	logic              adv;
	logic              s_xfer;
	logic [17:0]       cmd_q;
	logic [17:0]       stat_q;
	logic [3:0]        us_q [NUM_UNITS];
	logic              fresh_q;
	logic [17:0]       cmd_nxt;
	logic [17:0]       stat_nxt;
	logic [3:0]        us_nxt [NUM_UNITS];

	assign item_in.mode          = s_axis_tuser;
	assign item_in.pulse         = s_axis_tdata[5:0];
	assign item_in.ac_in         = s_axis_tdata[23:6];
	assign item_in.unit          = s_axis_tdata[26:24];
	assign item_in.result_code   = s_axis_tdata[30:27];
	assign item_in.length_error  = s_axis_tdata[31];
	assign item_in.compare_error = s_axis_tdata[32];
	assign item_in.eot_before    = s_axis_tdata[33];
	assign item_in.eot_after     = s_axis_tdata[34];
	assign item_in.attached_mask = s_axis_tdata[42:35];
	assign item_in.active_mask   = s_axis_tdata[50:43];
	assign item_in.locked_mask   = s_axis_tdata[58:51];

	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	mtcr_exec #(
		.NUM_UNITS(NUM_UNITS)
	) u_exec (
		.item     (item_s1),
		.cmd      (cmd_q),
		.stat     (stat_q),
		.us       (us_q),
		.fresh    (fresh_q),
		.cmd_nxt  (cmd_nxt),
		.stat_nxt (stat_nxt),
		.us_nxt   (us_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			cmd_q   <= '0;
			stat_q  <= '0;
			fresh_q <= 1'b1;
			for (int i = 0; i < NUM_UNITS; i++)
				us_q[i] <= '0;
		end else begin
			if (s_xfer)
				vld_s1 <= 1'b1;
			else if (adv)
				vld_s1 <= 1'b0;

			if (adv)
				vld_s2 <= 1'b1;
			else if (m_axis_tready)
				vld_s2 <= 1'b0;

			if (adv) begin
				cmd_q   <= cmd_nxt;
				stat_q  <= stat_nxt;
				fresh_q <= 1'b0;
				us_q    <= us_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer)
			item_s1 <= item_in;
		if (adv)
			res_s2 <= res_nxt;
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {3'b000, res_s2.start_unit, res_s2.start_function,
		res_s2.start_res, res_s2.irq, res_s2.status_word, res_s2.skip, res_s2.ac_out};

endmodule

@@ rtl/mtcr_checker.sv @@
// ----------------------------------------------------------------------------
// mtcr_checker: port checks for the tape controller register block
// Watches the result stream for properties that the register logic keeps.
// ----------------------------------------------------------------------------
module mtcr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [mtcr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// A waiting result may not change until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Function and drive fields are zero unless a start was accepted.
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[38] |-> m_axis_tdata[44:39] == 6'd0)
		else $error("start fields set without a start");

	// An interrupt needs error or done in the status shown with it.
	a_irq_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[37] |-> m_axis_tdata[36] || m_axis_tdata[25])
		else $error("interrupt without error or done");

	// The low status bits never read as set.
	a_stat_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[24:19] == 6'd0)
		else $error("low status bits set");

	// The result side is empty as reset is released.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result without input after reset");

endmodule

bind magtape_controller_registers mtcr_checker u_mtcr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
